// ===== hw/rtl/arrd_pkg.sv =====
package arrd_pkg;

  localparam int WORKERS     = 16;
  localparam int CLIENT_BITS = 16;
  localparam int QUEUE_DEPTH = 64;

  localparam int WID_W   = 4;
  localparam int CFG_W   = 5;
  localparam int STAT_W  = 4;
  localparam int SIG_W   = 8;
  localparam int OVL_W   = WID_W + 1;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SIG_W-1:0] SIG_MAX      = 8'd255;
  localparam logic [CFG_W-1:0] WC_RESET     = 5'd16;

  localparam logic [1:0] FUNC_REQ   = 2'd0;
  localparam logic [1:0] FUNC_READY = 2'd1;
  localparam logic [1:0] FUNC_DONE  = 2'd2;
  localparam logic [1:0] FUNC_ERROR = 2'd3;

  localparam logic [STAT_W-1:0] RES_AFFINE    = 4'd0;
  localparam logic [STAT_W-1:0] RES_QUEUE     = 4'd1;
  localparam logic [STAT_W-1:0] RES_OVERLOAD  = 4'd2;
  localparam logic [STAT_W-1:0] RES_NO_WORKER = 4'd3;
  localparam logic [STAT_W-1:0] RES_DISCARDED = 4'd4;
  localparam logic [STAT_W-1:0] RES_QUEUED    = 4'd5;
  localparam logic [STAT_W-1:0] RES_UNKNOWN   = 4'd6;
  localparam logic [STAT_W-1:0] RES_OVERFLOW  = 4'd7;
  localparam logic [STAT_W-1:0] RES_IGNORED   = 4'd8;

  typedef struct packed {
    logic load;
    logic eval;
  } ctrl_cmd_t;

endpackage

// ===== hw/rtl/arrd_ram.sv =====
module arrd_ram #(
  parameter int Width = 4,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/arrd_ctrl.sv =====
module arrd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output arrd_pkg::ctrl_cmd_t cmd_o,
  output logic                result_valid_o
);
  import arrd_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  logic state_q, state_d;
  logic done_q;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.eval = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.eval;
    end
  end

  assign busy_o         = (state_q == ST_EVAL);
  assign result_valid_o = done_q;

`ifndef ASSERT_OFF
  // a result follows each evaluation cycle, and only an evaluation cycle
  a_strobe_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_EVAL))
    else $error("result strobe without evaluation");
  a_eval_gives_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.eval |=> done_q)
    else $error("evaluation without result strobe");
`endif

endmodule

// ===== hw/rtl/arrd_datapath.sv =====
module arrd_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  arrd_pkg::ctrl_cmd_t            cmd_i,
  input  logic                           cfg_we_i,
  input  logic [arrd_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [1:0]                     func_i,
  input  logic [arrd_pkg::WID_W-1:0]     worker_id_i,
  input  logic [15:0]                    client_id_i,
  input  logic                           discard_i,
  output logic [arrd_pkg::STAT_W-1:0]    status_o,
  output logic [arrd_pkg::WID_W-1:0]     dest_worker_o,
  output logic                           all_ready_o
);
  import arrd_pkg::*;

  logic [CFG_W-1:0]       wc_q;
  logic [1:0]             func_q;
  logic [WID_W-1:0]       wid_q;
  logic [CLIENT_BITS-1:0] client_q;
  logic                   discard_q;

  logic [CLIENT_BITS-1:0] held_client_q [WORKERS];
  logic [CLIENT_BITS-1:0] held_client_d [WORKERS];
  logic [WORKERS-1:0]     held_valid_q, held_valid_d;
  logic [WORKERS-1:0]     registered_q, registered_d;
  logic [QPTR_W-1:0]      head_q, head_d, tail_q, tail_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [SIG_W-1:0]       sig_q, sig_d;
  logic [WID_W-1:0]       ptr_q, ptr_d;

  logic [STAT_W-1:0]      status_q, status_d;
  logic [WID_W-1:0]       dest_q, dest_d;
  logic                   all_q, all_d;

  logic [CFG_W-1:0]       limit;
  logic                   found;
  logic [WID_W-1:0]       match_idx;
  logic                   claim;
  logic                   reg_hit;
  logic [OVL_W-1:0]       ovl_nxt;
  logic                   ram_we;
  logic [WID_W-1:0]       ram_rdata;

  arrd_ram #(
    .Width (WID_W),
    .Depth (QUEUE_DEPTH)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (wid_q),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign limit = (wc_q < CFG_W'(WORKERS)) ? wc_q : CFG_W'(WORKERS);

  // highest matching index wins
  always_comb begin
    found     = 1'b0;
    match_idx = '0;
    for (int i = 0; i < WORKERS; i++) begin
      if (held_valid_q[i] && (held_client_q[i] == client_q) && (CFG_W'(i) < limit)) begin
        found     = 1'b1;
        match_idx = WID_W'(i);
      end
    end
  end

  assign ovl_nxt = OVL_W'(ptr_q) + OVL_W'(1);

  always_comb begin
    held_client_d = held_client_q;
    held_valid_d  = held_valid_q;
    registered_d  = registered_q;
    head_d        = head_q;
    tail_d        = tail_q;
    fill_d        = fill_q;
    sig_d         = sig_q;
    ptr_d         = ptr_q;
    status_d      = RES_IGNORED;
    dest_d        = '0;
    all_d         = 1'b0;
    claim         = 1'b0;
    reg_hit       = 1'b0;
    ram_we        = 1'b0;

    if (func_q == FUNC_REQ) begin
      if (discard_q) begin
        status_d = RES_DISCARDED;
      end else if (found) begin
        status_d = RES_AFFINE;
        dest_d   = match_idx;
        claim    = 1'b1;
      end else if (fill_q != '0) begin
        // pop the oldest ready worker
        status_d = RES_QUEUE;
        dest_d   = ram_rdata;
        head_d   = (head_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QPTR_W'(1);
        fill_d   = fill_q - FILL_W'(1);
        claim    = 1'b1;
      end else if (sig_q == '0) begin
        status_d = RES_NO_WORKER;
      end else begin
        status_d = RES_OVERLOAD;
        dest_d   = ptr_q;
        ptr_d    = ((SIG_W'(ovl_nxt) >= sig_q) || (ovl_nxt >= OVL_W'(WORKERS)))
                   ? '0 : WID_W'(ovl_nxt);
        claim    = 1'b1;
      end
      if (claim) begin
        held_client_d[dest_d] = client_q;
        held_valid_d[dest_d]  = 1'b1;
      end
    end else begin
      dest_d = wid_q;
      if (CFG_W'(wid_q) >= limit) begin
        status_d = RES_UNKNOWN;
      end else if (func_q == FUNC_READY || func_q == FUNC_DONE) begin
        reg_hit = registered_q[wid_q] || (func_q == FUNC_READY);
        if (func_q == FUNC_READY) begin
          registered_d[wid_q] = 1'b1;
          // saturate the count; flag only on a real change
          if (sig_q < SIG_MAX) begin
            sig_d = sig_q + SIG_W'(1);
            all_d = (sig_d == SIG_W'(wc_q));
          end
        end
        if (!reg_hit) begin
          status_d = RES_UNKNOWN;
        end else begin
          held_valid_d[wid_q] = 1'b0;
          if (fill_q < FILL_W'(QUEUE_DEPTH)) begin
            ram_we   = 1'b1;
            tail_d   = (tail_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QPTR_W'(1);
            fill_d   = fill_q + FILL_W'(1);
            status_d = RES_QUEUED;
          end else begin
            status_d = RES_OVERFLOW;
          end
        end
      end else begin
        status_d = RES_IGNORED;
      end
    end

    if (!cmd_i.eval) begin
      ram_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q         <= WC_RESET;
      held_valid_q <= '0;
      registered_q <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      fill_q       <= '0;
      sig_q        <= '0;
      ptr_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        wc_q <= cfg_wdata_i;
      end
      if (cmd_i.eval) begin
        held_valid_q <= held_valid_d;
        registered_q <= registered_d;
        head_q       <= head_d;
        tail_q       <= tail_d;
        fill_q       <= fill_d;
        sig_q        <= sig_d;
        ptr_q        <= ptr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q    <= func_i;
      wid_q     <= worker_id_i;
      client_q  <= CLIENT_BITS'(client_id_i);
      discard_q <= discard_i;
    end
    if (cmd_i.eval) begin
      held_client_q <= held_client_d;
      status_q      <= status_d;
      dest_q        <= dest_d;
      all_q         <= all_d;
    end
  end

  assign status_o      = status_q;
  assign dest_worker_o = dest_q;
  assign all_ready_o   = all_q;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(QUEUE_DEPTH))
    else $error("ready FIFO fill beyond depth");
  a_sig_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sig_q >= $past(sig_q))
    else $error("ready count decreased");
  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (fill_q == $past(fill_q) + FILL_W'(1)))
    else $error("FIFO write without fill increment");
`endif

endmodule

// ===== hw/rtl/affinity_round_robin_dispatcher_top.sv =====
// Channel   Handshake            Payload
// request   start_i / busy_o     func_i, worker_id_i, client_id_i, discard_i
// result    result_valid_o       status_o, dest_worker_o, all_ready_o
// config    cfg_we_i             cfg_wdata_i (worker_count)
//
// An event is taken when start_i is high and busy_o low; busy_o is high for the
// one evaluation cycle, so no new event is taken while one is being evaluated.
// The result strobe is high for one cycle, the cycle after evaluation; the
// receiver cannot stall it and the next event may be taken in that same cycle.
// Reset (rst_ni low, asynchronous) clears all control state; worker_count = 16.
module affinity_round_robin_dispatcher_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [1:0]                     func_i,
  input  logic [arrd_pkg::WID_W-1:0]     worker_id_i,
  input  logic [15:0]                    client_id_i,
  input  logic                           discard_i,
  output logic                           result_valid_o,
  output logic [arrd_pkg::STAT_W-1:0]    status_o,
  output logic [arrd_pkg::WID_W-1:0]     dest_worker_o,
  output logic                           all_ready_o,
  input  logic                           cfg_we_i,
  input  logic [arrd_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import arrd_pkg::*;

  ctrl_cmd_t cmd;

  arrd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_o          (cmd),
    .result_valid_o (result_valid_o)
  );

  arrd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .func_i        (func_i),
    .worker_id_i   (worker_id_i),
    .client_id_i   (client_id_i),
    .discard_i     (discard_i),
    .status_o      (status_o),
    .dest_worker_o (dest_worker_o),
    .all_ready_o   (all_ready_o)
  );

endmodule

// ===== test/affinity_round_robin_dispatcher_top_tb.sv =====
module affinity_round_robin_dispatcher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import arrd_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WID_W-1:0]  dest;
    logic              all_ready;
  } dispatch_t;

  // Tracks worker affinity, the ready queue and the overload pointer, and
  // checks each dispatch decision against the oldest one still owed.
  class dispatch_predictor;
    logic [CLIENT_BITS-1:0] held_client [WORKERS];
    bit                     held_valid [WORKERS];
    bit                     registered [WORKERS];
    logic [WID_W-1:0]       ready_queue [$];
    int unsigned            ready_signals;
    int unsigned            overload_ptr;
    int unsigned            worker_count;
    dispatch_t              expected_dispatches [$];
    int unsigned            errors;

    function new();
      foreach (held_client[i]) begin
        held_client[i] = '0;
        held_valid[i]  = 1'b0;
        registered[i]  = 1'b0;
      end
      ready_signals = 0;
      overload_ptr  = 0;
      worker_count  = WC_RESET;
      errors        = 0;
    endfunction

    function void predict_event(logic [1:0] func, logic [WID_W-1:0] wid,
                                logic [15:0] client, logic discard);
      dispatch_t   res;
      int unsigned lim;
      int unsigned nxt;
      bit          found;
      res   = '0;
      found = 1'b0;
      lim   = (worker_count < WORKERS) ? worker_count : WORKERS;
      if (func == FUNC_REQ) begin
        if (discard) begin
          res.status = RES_DISCARDED;
        end else begin
          // highest matching index wins
          for (int i = 0; i < lim; i++) begin
            if (held_valid[i] && held_client[i] == client) begin
              found    = 1'b1;
              res.dest = WID_W'(i);
            end
          end
          if (found) begin
            res.status = RES_AFFINE;
          end else if (ready_queue.size() > 0) begin
            res.dest   = ready_queue.pop_front();
            res.status = RES_QUEUE;
          end else if (ready_signals == 0) begin
            res.status = RES_NO_WORKER;
          end else begin
            res.dest = WID_W'(overload_ptr);
            nxt      = overload_ptr + 1;
            if (nxt >= ready_signals || nxt >= WORKERS) nxt = 0;
            overload_ptr = nxt;
            res.status   = RES_OVERLOAD;
          end
          if (res.status != RES_NO_WORKER) begin
            held_client[res.dest] = client;
            held_valid[res.dest]  = 1'b1;
          end
        end
      end else begin
        res.dest = wid;
        if (wid >= lim) begin
          res.status = RES_UNKNOWN;
        end else if (func == FUNC_ERROR) begin
          res.status = RES_IGNORED;
        end else begin
          if (func == FUNC_READY) begin
            registered[wid] = 1'b1;
            // saturate the count; flag only on an actual change
            if (ready_signals < SIG_MAX) begin
              ready_signals++;
              if (ready_signals == worker_count) res.all_ready = 1'b1;
            end
          end
          if (!registered[wid]) begin
            res.status = RES_UNKNOWN;
          end else begin
            held_valid[wid] = 1'b0;
            if (ready_queue.size() < QUEUE_DEPTH) begin
              ready_queue.push_back(wid);
              res.status = RES_QUEUED;
            end else begin
              res.status = RES_OVERFLOW;
            end
          end
        end
      end
      expected_dispatches.push_back(res);
    endfunction

    function void check_result(dispatch_t got);
      dispatch_t want;
      if (expected_dispatches.size() == 0) begin
        $error("result with nothing owed: status %0d dest %0d all_ready %0d",
               got.status, got.dest, got.all_ready);
        errors++;
        return;
      end
      want = expected_dispatches.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.dest !== want.dest) begin
        $error("dest_worker: expected %0d, actual %0d", want.dest, got.dest);
        errors++;
      end
      if (got.all_ready !== want.all_ready) begin
        $error("all_ready: expected %0d, actual %0d", want.all_ready, got.all_ready);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [1:0]        func_i;
  logic [WID_W-1:0]  worker_id_i;
  logic [15:0]       client_id_i;
  logic              discard_i;
  logic              result_valid_o;
  logic [STAT_W-1:0] status_o;
  logic [WID_W-1:0]  dest_worker_o;
  logic              all_ready_o;
  logic              cfg_we_i;
  logic [CFG_W-1:0]  cfg_wdata_i;

  dispatch_predictor predictor;
  int unsigned       cycle_count = 0;
  logic [15:0]       client_pool [0:7] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                           16'h1234, 16'h00FF, 16'hAAAA, 16'h5555};
  int unsigned       phase_worker_count [0:PHASES-1] = '{16, 1, 7, 16, 12, 2, 16, 5};

  affinity_round_robin_dispatcher_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .worker_id_i    (worker_id_i),
    .client_id_i    (client_id_i),
    .discard_i      (discard_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .dest_worker_o  (dest_worker_o),
    .all_ready_o    (all_ready_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      predictor.check_result(dispatch_t'{status_o, dest_worker_o, all_ready_o});
    end
  end

  // Hold start until the transfer is taken, then owe its result.
  task automatic send_event(input logic [1:0] func, input logic [WID_W-1:0] wid,
                            input logic [15:0] client, input logic discard);
    @(negedge clk_i);
    start_i     <= 1'b1;
    func_i      <= func;
    worker_id_i <= wid;
    client_id_i <= client;
    discard_i   <= discard;
    do @(posedge clk_i); while (busy_o);
    predictor.predict_event(func, wid, client, discard);
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  task automatic write_worker_count(input int unsigned value);
    @(negedge clk_i);
    start_i <= 1'b0;
    while (predictor.expected_dispatches.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    predictor.worker_count = value;
  endtask

  task automatic random_event(input int unsigned req_pct);
    logic [1:0]       func;
    logic [WID_W-1:0] wid;
    logic [15:0]      client;
    logic             discard;
    int unsigned      lim;
    int unsigned      pick;
    lim     = (predictor.worker_count < WORKERS) ? predictor.worker_count : WORKERS;
    wid     = WID_W'($urandom_range(0, WORKERS - 1));
    client  = ($urandom_range(0, 9) < 7) ? client_pool[$urandom_range(0, 7)]
                                         : 16'($urandom_range(0, 65535));
    discard = ($urandom_range(0, 15) == 0);
    pick    = $urandom_range(0, 99);
    if (pick < req_pct) begin
      func = FUNC_REQ;
    end else begin
      pick = $urandom_range(0, 99);
      func = (pick < 45) ? FUNC_READY : (pick < 90) ? FUNC_DONE : FUNC_ERROR;
      // mostly workers inside the active range
      if ($urandom_range(0, 9) != 0) wid = WID_W'($urandom_range(0, lim - 1));
    end
    send_event(func, wid, client, discard);
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    func_i      = FUNC_REQ;
    worker_id_i = '0;
    client_id_i = '0;
    discard_i   = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    predictor   = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_event(FUNC_REQ,   4'd15, 16'hFFFF, 1'b1);
    send_event(FUNC_REQ,   4'd0,  16'h0000, 1'b0);
    send_event(FUNC_DONE,  4'd3,  16'h0000, 1'b0);
    send_event(FUNC_ERROR, 4'd15, 16'hFFFF, 1'b1);
    send_event(FUNC_READY, 4'd15, 16'h0000, 1'b0);
    send_event(FUNC_REQ,   4'd0,  16'hFFFF, 1'b0);
    send_event(FUNC_REQ,   4'd0,  16'hFFFF, 1'b0);
    send_event(FUNC_REQ,   4'd0,  16'h0000, 1'b0);
    send_event(FUNC_REQ,   4'd0,  16'h0001, 1'b0);
    send_event(FUNC_DONE,  4'd15, 16'h0000, 1'b0);
    write_worker_count(3);
    send_event(FUNC_READY, 4'd15, 16'h0000, 1'b0);
    send_event(FUNC_READY, 4'd0,  16'h0000, 1'b0);
    send_event(FUNC_READY, 4'd2,  16'h0000, 1'b0);
    send_event(FUNC_READY, 4'd0,  16'h0000, 1'b0);
    send_event(FUNC_DONE,  4'd1,  16'h0000, 1'b0);
    send_event(FUNC_ERROR, 4'd2,  16'h0000, 1'b0);
    repeat (6) send_event(FUNC_REQ, 4'd0, 16'h8000, 1'b0);
    send_event(FUNC_REQ,   4'd0,  16'h7FFF, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      write_worker_count(phase_worker_count[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // phase 3 runs back to back with no gaps
        if (p != 3 && $urandom_range(0, 99) < 20) idle_cycles($urandom_range(1, 3));
        random_event((p % 2 == 0) ? 30 : 75);
      end
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (predictor.expected_dispatches.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (predictor.errors == 0 && predictor.expected_dispatches.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/arrd_pkg.sv
hw/rtl/arrd_ram.sv
hw/rtl/arrd_ctrl.sv
hw/rtl/arrd_datapath.sv
hw/rtl/affinity_round_robin_dispatcher_top.sv
test/affinity_round_robin_dispatcher_top_tb.sv
